// ===== src/plcm_pkg.sv =====
// ----------------------------------------------------------------------------
// plcm_pkg
// Shared types and constants for the piecewise-linear color ramp.
// ----------------------------------------------------------------------------
`default_nettype none

package plcm_pkg;

  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned NUM_CHAN   = 4;
  localparam int unsigned KNOT_REGS  = 7;
  localparam int unsigned PROD_W     = 2 * CHAN_W;
  localparam int unsigned QUO_STEPS  = CHAN_W;
  localparam int unsigned CNT_W      = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 5 * CHAN_W;
  localparam int unsigned FIFO_DEPTH = 4;

  // channel lanes
  localparam int unsigned CH_RED   = 0;
  localparam int unsigned CH_GREEN = 1;
  localparam int unsigned CH_BLUE  = 2;
  localparam int unsigned CH_ALPHA = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KNOT_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KNOT_FIRST = 3'd1;

  localparam logic [CNT_W-1:0] COUNT_RESET = 3'd2;
  localparam logic [CNT_W-1:0] COUNT_MIN   = 3'd2;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] chans_t;

  typedef struct packed {
    chan_t pos;
    chan_t red;
    chan_t green;
    chan_t blue;
    chan_t alpha;
  } knot_t;

  localparam knot_t KNOT0_RESET = '{pos: 8'h00, red: 8'h00, green: 8'h00, blue: 8'h00,
                                    alpha: 8'hFF};
  localparam knot_t KNOT1_RESET = '{pos: 8'hFF, red: 8'hFF, green: 8'hFF, blue: 8'hFF,
                                    alpha: 8'hFF};
  localparam knot_t KNOT_CLEAR  = '{pos: 8'h00, red: 8'h00, green: 8'h00, blue: 8'h00,
                                    alpha: 8'h00};

  // queued word: base color, sign of the step, numerator and divisor
  typedef struct packed {
    chans_t                           base;
    logic [NUM_CHAN-1:0]              neg;
    logic [NUM_CHAN-1:0][PROD_W-1:0]  prod;
    chan_t                            den;
  } work_t;

  // state of one quotient stage
  typedef struct packed {
    logic [NUM_CHAN-1:0][PROD_W-1:0]  rem;
    chans_t                           quo;
    chans_t                           base;
    logic [NUM_CHAN-1:0]              neg;
    chan_t                            den;
  } div_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

// ===== src/plcm_if.sv =====
// ----------------------------------------------------------------------------
// plcm_if
// Valid/ready channels for level words in and color words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface plcm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] level;

  modport source (output valid, output level, input ready);
  modport sink   (input valid, input level, output ready);
endinterface

interface plcm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;

  modport source (output valid, output red, output green, output blue, output alpha,
                  input ready);
  modport sink   (input valid, input red, input green, input blue, input alpha,
                  output ready);
endinterface

`default_nettype wire

// ===== src/plcm_front.sv =====
// ----------------------------------------------------------------------------
// plcm_front
// Accepts levels, picks the segment or clamp knot, forms the scaled step.
// ----------------------------------------------------------------------------
`default_nettype none

module plcm_front #(
  parameter int unsigned NUM_KNOTS = 7
) (
  input  logic                                clk,
  input  logic                                rst_n,
  plcm_in_if.sink                             in_ch,
  input  logic [plcm_pkg::CNT_W-1:0]          knot_count_i,
  input  plcm_pkg::knot_t                     knots_i [NUM_KNOTS],
  input  plcm_pkg::q_status_t                 q_status_i,
  output logic                                push_o,
  output plcm_pkg::work_t                     work_o
);

  localparam int unsigned KIDX_W = $clog2(NUM_KNOTS);
  localparam logic [plcm_pkg::CNT_W-1:0] NK = plcm_pkg::CNT_W'(NUM_KNOTS);
  localparam logic [KIDX_W-1:0] KIDX_MAX = KIDX_W'(NUM_KNOTS - 1);

  function automatic plcm_pkg::chans_t knot_chans(input plcm_pkg::knot_t k);
    plcm_pkg::chans_t c;
    c[plcm_pkg::CH_RED]   = k.red;
    c[plcm_pkg::CH_GREEN] = k.green;
    c[plcm_pkg::CH_BLUE]  = k.blue;
    c[plcm_pkg::CH_ALPHA] = k.alpha;
    return c;
  endfunction

  logic                          s1_valid_r;
  plcm_pkg::chan_t               s1_level_r;
  logic [KIDX_W-1:0]             s1_k_r;
  logic                          s1_clamp_r;

  logic [plcm_pkg::CNT_W-1:0]    n_eff;
  logic [KIDX_W-1:0]             last;
  logic [KIDX_W-1:0]             k_nxt;
  logic                          clamp_nxt;

  assign in_ch.ready = !s1_valid_r || !q_status_i.full;
  assign push_o      = s1_valid_r && !q_status_i.full;

  // classify: clamp high, clamp low, or the last knot at or below the level
  always_comb begin
    logic [KIDX_W-1:0] seg_k;
    n_eff = (knot_count_i < plcm_pkg::COUNT_MIN) ? plcm_pkg::COUNT_MIN : knot_count_i;
    if (n_eff > NK) begin
      n_eff = NK;
    end
    last  = KIDX_W'(n_eff - 3'd1);
    seg_k = '0;
    for (int i = 0; i < NUM_KNOTS - 1; i++) begin
      if ((KIDX_W'(i) < last) && (knots_i[i].pos <= in_ch.level)) begin
        seg_k = KIDX_W'(i);
      end
    end
    if (in_ch.level >= knots_i[last].pos) begin
      k_nxt     = last;
      clamp_nxt = 1'b1;
    end else if (in_ch.level < knots_i[0].pos) begin
      k_nxt     = '0;
      clamp_nxt = 1'b1;
    end else begin
      k_nxt     = seg_k;
      clamp_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_level_r <= in_ch.level;
      s1_k_r     <= k_nxt;
      s1_clamp_r <= clamp_nxt;
    end
  end

  // fetch both knots and scale the color step by the offset into the segment
  always_comb begin
    plcm_pkg::knot_t   ka;
    plcm_pkg::knot_t   kb;
    logic [KIDX_W-1:0] kb_idx;
    plcm_pkg::chans_t  ca;
    plcm_pkg::chans_t  cb;
    plcm_pkg::chan_t   t;
    plcm_pkg::chan_t   mag;
    kb_idx = (s1_k_r == KIDX_MAX) ? s1_k_r : s1_k_r + 1'b1;
    ka     = knots_i[s1_k_r];
    kb     = knots_i[kb_idx];
    ca     = knot_chans(ka);
    cb     = knot_chans(kb);
    t      = s1_level_r - ka.pos;
    work_o.base = ca;
    work_o.den  = s1_clamp_r ? 8'd1 : (kb.pos - ka.pos);
    for (int ch = 0; ch < plcm_pkg::NUM_CHAN; ch++) begin
      work_o.neg[ch] = cb[ch] < ca[ch];
      mag = work_o.neg[ch] ? (ca[ch] - cb[ch]) : (cb[ch] - ca[ch]);
      work_o.prod[ch] = s1_clamp_r ? '0
                      : plcm_pkg::PROD_W'(mag) * plcm_pkg::PROD_W'(t);
    end
  end

endmodule

`default_nettype wire

// ===== src/plcm_fifo.sv =====
// ----------------------------------------------------------------------------
// plcm_fifo
// Short queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module plcm_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_i,
  input  plcm_pkg::work_t     wdata_i,
  input  logic                pop_i,
  output plcm_pkg::work_t     rdata_o,
  output plcm_pkg::q_status_t status_o
);

  localparam int unsigned PTR_W = $clog2(plcm_pkg::FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(plcm_pkg::FIFO_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH = CNT_W'(plcm_pkg::FIFO_DEPTH);

  plcm_pkg::work_t  mem_r [plcm_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign status_o.full  = (count_r == DEPTH);
  assign status_o.empty = (count_r == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign rdata_o = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/plcm_back.sv =====
// ----------------------------------------------------------------------------
// plcm_back
// Pipelined floor division, one quotient bit per stage, and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module plcm_back (
  input  logic                clk,
  input  logic                rst_n,
  input  plcm_pkg::q_status_t q_status_i,
  input  plcm_pkg::work_t     work_i,
  output logic                pop_o,
  plcm_out_if.source          out_ch
);

  localparam int unsigned STEPS = plcm_pkg::QUO_STEPS;

  function automatic plcm_pkg::div_t div_load(input plcm_pkg::work_t w);
    plcm_pkg::div_t s;
    s.rem  = w.prod;
    s.quo  = '0;
    s.base = w.base;
    s.neg  = w.neg;
    s.den  = w.den;
    return s;
  endfunction

  // restoring step: try the divisor shifted to quotient bit b
  function automatic plcm_pkg::div_t div_step(input plcm_pkg::div_t s, input int b);
    plcm_pkg::div_t               r;
    logic [plcm_pkg::PROD_W-1:0]  ds;
    r  = s;
    ds = plcm_pkg::PROD_W'(s.den) << b;
    for (int ch = 0; ch < plcm_pkg::NUM_CHAN; ch++) begin
      if (s.rem[ch] >= ds) begin
        r.rem[ch]    = s.rem[ch] - ds;
        r.quo[ch][b] = 1'b1;
      end
    end
    return r;
  endfunction

  // falling step rounds toward minus infinity: subtract one more on a remainder
  function automatic plcm_pkg::chans_t div_finish(input plcm_pkg::div_t s);
    plcm_pkg::chans_t c;
    for (int ch = 0; ch < plcm_pkg::NUM_CHAN; ch++) begin
      c[ch] = s.neg[ch]
            ? s.base[ch] - s.quo[ch] - plcm_pkg::CHAN_W'(s.rem[ch] != '0)
            : s.base[ch] + s.quo[ch];
    end
    return c;
  endfunction

  plcm_pkg::div_t    st_r [STEPS+1];
  logic [STEPS:0]    vld_r;
  logic              out_valid_r;
  plcm_pkg::chans_t  res_r;
  logic              adv;

  assign adv   = !out_valid_r || out_ch.ready;
  assign pop_o = adv && !q_status_i.empty;

  assign out_ch.valid = out_valid_r;
  assign out_ch.red   = res_r[plcm_pkg::CH_RED];
  assign out_ch.green = res_r[plcm_pkg::CH_GREEN];
  assign out_ch.blue  = res_r[plcm_pkg::CH_BLUE];
  assign out_ch.alpha = res_r[plcm_pkg::CH_ALPHA];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[STEPS-1:0], pop_o};
      out_valid_r <= vld_r[STEPS];
    end
  end

  // advance the whole pipe together; hold everything while the output stalls
  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0] <= div_load(work_i);
      for (int j = 0; j < STEPS; j++) begin
        st_r[j+1] <= div_step(st_r[j], STEPS - 1 - j);
      end
      res_r <= div_finish(st_r[STEPS]);
    end
  end

endmodule

`default_nettype wire

// ===== src/piecewise_linear_colormap.sv =====
// ----------------------------------------------------------------------------
// piecewise_linear_colormap
// Maps an 8-bit level to RGBA by interpolating between configured knots.
// ----------------------------------------------------------------------------
//  port     | dir | handshake   | word
//  ---------+-----+-------------+-------------------------------------------
//  in_ch    | in  | valid/ready | level[7:0]
//  out_ch   | out | valid/ready | red, green, blue, alpha [7:0] each
//  cfg_*    | in  | cfg_we only | cfg_index[2:0], cfg_data[39:0]
//
//  One word accepted per clock while not stalled; each result passes through
//  the eight-stage quotient pipeline in the back end.
//  Reset is synchronous; knots take their power-on values at once, no sweep.
//  An output stall freezes the back end; the four-word queue absorbs the
//  front end's words until full, then in_ch.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module piecewise_linear_colormap #(
  parameter int unsigned MAX_KNOTS = 7
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  plcm_in_if.sink                              in_ch,
  plcm_out_if.source                           out_ch,
  input  logic                                 cfg_we,
  input  logic [plcm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [plcm_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int unsigned NUM_KNOTS =
    (MAX_KNOTS < plcm_pkg::KNOT_REGS) ? MAX_KNOTS : plcm_pkg::KNOT_REGS;

  logic [plcm_pkg::CNT_W-1:0] knot_count_r;
  plcm_pkg::knot_t            knots_r [NUM_KNOTS];

  logic                       push;
  logic                       pop;
  plcm_pkg::work_t            push_data;
  plcm_pkg::work_t            head_data;
  plcm_pkg::q_status_t        q_status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      knot_count_r <= plcm_pkg::COUNT_RESET;
      for (int i = 0; i < NUM_KNOTS; i++) begin
        knots_r[i] <= (i == 0) ? plcm_pkg::KNOT0_RESET
                    : (i == 1) ? plcm_pkg::KNOT1_RESET
                    : plcm_pkg::KNOT_CLEAR;
      end
    end else if (cfg_we) begin
      if (cfg_index == plcm_pkg::REG_KNOT_COUNT) begin
        knot_count_r <= cfg_data[plcm_pkg::CNT_W-1:0];
      end
      // drop writes to knots beyond the stored ones
      for (int i = 0; i < NUM_KNOTS; i++) begin
        if (cfg_index == plcm_pkg::REG_KNOT_FIRST + plcm_pkg::CFG_IDX_W'(i)) begin
          knots_r[i] <= cfg_data;
        end
      end
    end
  end

  plcm_front #(
    .NUM_KNOTS (NUM_KNOTS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .knot_count_i (knot_count_r),
    .knots_i      (knots_r),
    .q_status_i   (q_status),
    .push_o       (push),
    .work_o       (push_data)
  );

  plcm_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_i   (push),
    .wdata_i  (push_data),
    .pop_i    (pop),
    .rdata_o  (head_data),
    .status_o (q_status)
  );

  plcm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_status_i (q_status),
    .work_i     (head_data),
    .pop_o      (pop),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

// ===== src/plcm_checker.sv =====
// ----------------------------------------------------------------------------
// plcm_checker
// Port-level checks on the color ramp, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module plcm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue,
  input logic [7:0] out_alpha
);

  // a stalled result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_green)
                                && $stable(out_blue) && $stable(out_alpha))
    else $error("result word changed while stalled");

  // pipeline is empty after reset, so no result word is shown just after it
  a_reset_drain: assert property (@(posedge clk)
    !rst_n |=> !out_valid ##1 !out_valid)
    else $error("result word shown right after reset");

  // front end is free to take a word right after reset
  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready after reset");

endmodule

bind piecewise_linear_colormap plcm_checker u_plcm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_red   (out_ch.red),
  .out_green (out_ch.green),
  .out_blue  (out_ch.blue),
  .out_alpha (out_ch.alpha)
);

`default_nettype wire

// ===== verif/tb_piecewise_linear_colormap.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_piecewise_linear_colormap
// Self-checking bench for the color ramp. Levels stream in through a
// valid/ready driver and a monitor checks every RGBA word against a
// predictor of the ramp. The bench reloads the knot table between phases:
// directed corner cases first, then randomized tables and levels. Random
// stalls come from both sides, and one long output stall backs the block up.
// ----------------------------------------------------------------------------

module tb_piecewise_linear_colormap;

  localparam int unsigned MAX_KNOTS = 7;
  localparam int unsigned HOLD_CYCLES = 150;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [plcm_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [plcm_pkg::CFG_DATA_W-1:0] cfg_data;

  plcm_in_if  in_bus ();
  plcm_out_if out_bus ();

  piecewise_linear_colormap #(
    .MAX_KNOTS(MAX_KNOTS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_bus),
    .out_ch   (out_bus),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // bench copy of the knot table
  logic [plcm_pkg::CNT_W-1:0] ramp_count;
  plcm_pkg::knot_t ramp_knots [plcm_pkg::KNOT_REGS];

  plcm_pkg::chan_t  level_queue [$];
  plcm_pkg::chans_t color_expect [$];
  string  chan_name [plcm_pkg::NUM_CHAN] = '{"red", "green", "blue", "alpha"};

  int  mismatches = 0;
  int  src_gap = 0;
  int  sink_gap = 0;
  bit  src_idle_en = 1'b1;
  bit  sink_idle_en = 1'b1;
  int  hold_req = 0;
  int  hold_seen;
  int  hold_left;

  function automatic plcm_pkg::chans_t knot_chans(input plcm_pkg::knot_t kn);
    plcm_pkg::chans_t c;
    c[plcm_pkg::CH_RED]   = kn.red;
    c[plcm_pkg::CH_GREEN] = kn.green;
    c[plcm_pkg::CH_BLUE]  = kn.blue;
    c[plcm_pkg::CH_ALPHA] = kn.alpha;
    return c;
  endfunction

  function automatic plcm_pkg::chans_t ramp_color(input plcm_pkg::chan_t lvl);
    int unsigned n;
    int unsigned last;
    int unsigned k;
    int t;
    int d;
    int num;
    int q;
    int v;
    plcm_pkg::chans_t lo;
    plcm_pkg::chans_t hi;
    plcm_pkg::chans_t res;
    n = (ramp_count < plcm_pkg::COUNT_MIN) ? plcm_pkg::COUNT_MIN : ramp_count;
    if (n > MAX_KNOTS) n = MAX_KNOTS;
    last = n - 1;
    // clamp above the last knot first, then below the first
    if (lvl >= ramp_knots[last].pos) return knot_chans(ramp_knots[last]);
    if (lvl < ramp_knots[0].pos) return knot_chans(ramp_knots[0]);
    k = 0;
    for (int i = 0; i < last; i++) begin
      if (ramp_knots[i].pos <= lvl) k = i;
    end
    lo = knot_chans(ramp_knots[k]);
    hi = knot_chans(ramp_knots[k + 1]);
    t = int'(lvl) - int'(ramp_knots[k].pos);
    d = int'(ramp_knots[k + 1].pos) - int'(ramp_knots[k].pos);
    for (int c = 0; c < plcm_pkg::NUM_CHAN; c++) begin
      v = int'(lo[c]);
      if (d > 0) begin
        num = (int'(hi[c]) - int'(lo[c])) * t;
        q = num / d;
        // round toward minus infinity on a falling channel
        if (num < 0 && q * d != num) q = q - 1;
        v = v + q;
      end
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      res[c] = v[plcm_pkg::CHAN_W-1:0];
    end
    return res;
  endfunction

  task automatic check_word();
    plcm_pkg::chans_t got;
    plcm_pkg::chans_t want;
    got[plcm_pkg::CH_RED]   = out_bus.red;
    got[plcm_pkg::CH_GREEN] = out_bus.green;
    got[plcm_pkg::CH_BLUE]  = out_bus.blue;
    got[plcm_pkg::CH_ALPHA] = out_bus.alpha;
    if (color_expect.size() == 0) begin
      $error("unexpected color word: red %0d green %0d blue %0d alpha %0d",
             got[plcm_pkg::CH_RED], got[plcm_pkg::CH_GREEN],
             got[plcm_pkg::CH_BLUE], got[plcm_pkg::CH_ALPHA]);
      mismatches++;
      return;
    end
    want = color_expect.pop_front();
    for (int c = 0; c < plcm_pkg::NUM_CHAN; c++) begin
      if (got[c] !== want[c]) begin
        $error("%s: expected %0d, got %0d", chan_name[c], want[c], got[c]);
        mismatches++;
      end
    end
  endtask

  // write the count word and all seven knots, then mirror them
  task automatic load_ramp(input logic [plcm_pkg::CFG_DATA_W-1:0] count_word,
                           input plcm_pkg::knot_t kn [plcm_pkg::KNOT_REGS]);
    for (int r = 0; r <= plcm_pkg::KNOT_REGS; r++) begin
      cfg_we    <= 1'b1;
      cfg_index <= r[plcm_pkg::CFG_IDX_W-1:0];
      if (r == plcm_pkg::REG_KNOT_COUNT) cfg_data <= count_word;
      else cfg_data <= kn[r - int'(plcm_pkg::REG_KNOT_FIRST)];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    ramp_count = count_word[plcm_pkg::CNT_W-1:0];
    ramp_knots = kn;
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (level_queue.size() != 0 || in_bus.valid || color_expect.size() != 0)
      @(posedge clk);
  endtask

  // level driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      in_bus.level <= '0;
    end else begin
      if (in_bus.valid && in_bus.ready) color_expect.push_back(ramp_color(in_bus.level));
      if (!in_bus.valid || in_bus.ready) begin
        if (src_gap != 0) begin
          src_gap = src_gap - 1;
          in_bus.valid <= 1'b0;
        end else if (level_queue.size() != 0) begin
          in_bus.valid <= 1'b1;
          in_bus.level <= level_queue.pop_front();
          if (src_idle_en && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 10);
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // long output stall, started on request
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_seen <= 0;
      hold_left <= 0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // color monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) check_word();
      if (hold_left != 0) begin
        out_bus.ready <= 1'b0;
      end else if (sink_gap != 0) begin
        sink_gap = sink_gap - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
        if (sink_idle_en && $urandom_range(0, 7) == 0) sink_gap = $urandom_range(1, 10);
      end
    end
  end

  initial begin
    plcm_pkg::knot_t kn [plcm_pkg::KNOT_REGS];
    int dir_a [$] = '{0, 1, 2, 85, 127, 128, 170, 254, 255};
    int dir_b [$] = '{0, 9, 10, 11, 39, 40, 61, 100, 159, 199, 254, 255};
    int dir_c [$] = '{0, 49, 50, 255};
    int pos_pick [plcm_pkg::KNOT_REGS];
    int style;
    int cnt;
    int base;
    int lv;
    logic [63:0] r64;
    logic [plcm_pkg::CFG_DATA_W-1:0] count_word;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_bus.valid = 1'b0;
    in_bus.level = '0;
    out_bus.ready = 1'b0;
    ramp_count = plcm_pkg::COUNT_RESET;
    ramp_knots[0] = plcm_pkg::KNOT0_RESET;
    ramp_knots[1] = plcm_pkg::KNOT1_RESET;
    for (int i = 2; i < plcm_pkg::KNOT_REGS; i++) ramp_knots[i] = plcm_pkg::KNOT_CLEAR;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // power-on ramp: black to white
    foreach (dir_a[i]) level_queue.push_back(dir_a[i][plcm_pkg::CHAN_W-1:0]);
    wait_drained();

    // all seven knots, rising and falling channels, full-scale last knot
    kn[0] = 40'h0A_00000000;
    kn[1] = 40'h28_FF8000FF;
    kn[2] = 40'h50_00FF4010;
    kn[3] = 40'h78_3300FF80;
    kn[4] = 40'hA0_FFFF0000;
    kn[5] = 40'hC8_01020304;
    kn[6] = 40'hFF_FFFFFFFF;
    load_ramp(40'd7, kn);
    foreach (dir_b[i]) level_queue.push_back(dir_b[i][plcm_pkg::CHAN_W-1:0]);
    wait_drained();

    // count below two saturates; second knot sits below the first
    kn[0] = 40'h64_11223344;
    kn[1] = 40'h32_AABBCCDD;
    for (int i = 2; i < plcm_pkg::KNOT_REGS; i++) kn[i] = '0;
    load_ramp(40'd1, kn);
    foreach (dir_c[i]) level_queue.push_back(dir_c[i][plcm_pkg::CHAN_W-1:0]);
    wait_drained();

    for (int ph = 0; ph < 10; ph++) begin
      style = ph % 4;
      src_idle_en  = !(ph == 9 || ph == 5 || ph == 3);
      sink_idle_en = !(ph == 9 || ph == 6);
      for (int i = 0; i < plcm_pkg::KNOT_REGS; i++) begin
        r64 = {$urandom(), $urandom()};
        kn[i] = r64[39:0];
        if (style == 2) begin
          kn[i].red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          kn[i].green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          kn[i].blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          kn[i].alpha = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
      end
      // well-formed tables keep positions rising; style 1 leaves them scrambled
      if (style != 1) begin
        base = $urandom_range(0, 200);
        for (int i = 0; i < plcm_pkg::KNOT_REGS; i++) begin
          if (style == 3) begin
            pos_pick[i] = base;
            base = base + $urandom_range(0, 3);
          end else begin
            pos_pick[i] = $urandom_range(0, 255);
          end
        end
        pos_pick.sort();
        for (int i = 0; i < plcm_pkg::KNOT_REGS; i++) begin
          kn[i].pos = pos_pick[i][plcm_pkg::CHAN_W-1:0];
        end
      end
      cnt = (ph % 3 == 0) ? 7 : $urandom_range(0, 7);
      r64 = {$urandom(), $urandom()};
      count_word = {r64[plcm_pkg::CFG_DATA_W-1:plcm_pkg::CNT_W], cnt[plcm_pkg::CNT_W-1:0]};
      load_ramp(count_word, kn);
      if (ph == 3) hold_req = hold_req + 1;
      repeat (170) begin
        if ($urandom_range(0, 3) == 0)
          lv = int'(kn[$urandom_range(0, plcm_pkg::KNOT_REGS - 1)].pos)
             + $urandom_range(0, 2) - 1;
        else
          lv = $urandom_range(0, 255);
        level_queue.push_back(lv[plcm_pkg::CHAN_W-1:0]);
      end
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0 && color_expect.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== sim.f =====
src/plcm_pkg.sv
src/plcm_if.sv
src/plcm_front.sv
src/plcm_fifo.sv
src/plcm_back.sv
src/piecewise_linear_colormap.sv
src/plcm_checker.sv
verif/tb_piecewise_linear_colormap.sv
